// ===== rtl/decimal_price_parser_macros.svh =====
// Assertion macros used by the price parser top level.
`ifndef DECIMAL_PRICE_PARSER_MACROS_SVH
`define DECIMAL_PRICE_PARSER_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define DPP_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define DPP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/dpp_pkg.sv =====
// Types, constants and helper functions for the decimal price parser.
`default_nettype none

package dpp_pkg;

    localparam int FRAC_PLACES = 6;

    function automatic logic [63:0] pow10(input int n);
        logic [63:0] p;
        p = 64'd1;
        for (int i = 0; i < n; i++)
        begin
            p = p * 64'd10;
        end
        return p;
    endfunction

    localparam logic [63:0] SCALE = pow10(FRAC_PLACES);
    localparam int FRAC_W = $clog2(SCALE);
    localparam int CNT_W  = $clog2(FRAC_PLACES + 1);

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_DOT   = 8'h2e;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_MINUS = 8'h2d;

    typedef enum logic [1:0] {
        PH_START = 2'd0,
        PH_WHOLE = 2'd1,
        PH_FRAC  = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NEG_EMPTY = 3'd1,
        ST_NO_DIGITS = 3'd2,
        ST_BAD_WHOLE = 3'd3,
        ST_NO_WHOLE  = 3'd4,
        ST_BAD_FRAC  = 3'd5,
        ST_OVERFLOW  = 3'd6
    } status_t;

    typedef struct packed {
        logic [7:0] character;
        logic       last_char;
        logic       empty_marker;
    } in_item_t;

    typedef struct packed {
        logic [63:0] price_micro;
        logic [2:0]  status;
    } out_item_t;

    // Place value of the next fraction digit, already padded to full width.
    function automatic logic [FRAC_W-1:0] frac_weight(input logic [CNT_W-1:0] cnt);
        logic [FRAC_W-1:0] w;
        w = '0;
        for (int i = 0; i < FRAC_PLACES; i++)
        begin
            if (cnt == CNT_W'(i))
            begin
                w = FRAC_W'(pow10(FRAC_PLACES - 1 - i));
            end
        end
        return w;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/dpp_core.sv =====
// Parser state and per-character update; forms the result on the last character.
`default_nettype none

module dpp_core import dpp_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      take,
    input  wire in_item_t  item,
    output logic           res_valid,
    output out_item_t      res
);

    phase_t              phase_reg, phase_next;
    status_t             err_reg, err_next;
    logic [63:0]         whole_reg, whole_next;
    logic                seen_reg, seen_next;
    logic [63:0]         total_reg, total_next;
    logic                tovf_reg, tovf_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;

    // Per-character datapath
    logic                is_digit;
    logic [3:0]          digit;
    logic                whole_path;
    logic [67:0]         whole_mul;
    logic                whole_ovf;
    logic [63:0]         digit_scaled;
    logic [67:0]         total_mul;
    logic [FRAC_W-1:0]   frac_term;
    logic [64:0]         total_add;

    // Values the string reaches with this item, before the end-of-string clear
    phase_t              phase_upd;
    status_t             err_upd;
    logic [63:0]         whole_upd;
    logic                seen_upd;
    logic [63:0]         total_upd;
    logic                tovf_upd;
    logic [CNT_W-1:0]    cnt_upd;

    assign is_digit  = (item.character >= CH_ZERO) && (item.character <= CH_NINE);
    assign digit     = item.character[3:0];
    assign whole_mul = ({4'b0, whole_reg} << 3) + ({4'b0, whole_reg} << 1) + 68'(digit);
    assign whole_ovf = |whole_mul[67:64];

    // Whole digits shift the scaled total by ten and add the digit at full scale
    assign digit_scaled = 64'(digit) * SCALE;
    assign total_mul = ({4'b0, total_reg} << 3) + ({4'b0, total_reg} << 1)
                       + {4'b0, digit_scaled};

    // Fraction digits add in at their padded place value
    assign frac_term = FRAC_W'({{(FRAC_W-4){1'b0}}, digit} * frac_weight(cnt_reg));
    assign total_add = {1'b0, total_reg} + 65'(frac_term);

    assign whole_path = !item.empty_marker && (err_reg == ST_OK) &&
                        (((phase_reg == PH_START) && (item.character != CH_MINUS) &&
                          (item.character != CH_PLUS)) || (phase_reg == PH_WHOLE));

    // Next state
    always_comb
    begin
        phase_upd = phase_reg;
        err_upd   = err_reg;
        whole_upd = whole_reg;
        seen_upd  = seen_reg;
        total_upd = total_reg;
        tovf_upd  = tovf_reg;
        cnt_upd   = cnt_reg;

        if (item.empty_marker)
        begin
            if ((phase_reg == PH_START) && (err_reg == ST_OK))
            begin
                err_upd = ST_NEG_EMPTY;
            end
        end
        else if (err_reg == ST_OK)
        begin
            case (phase_reg)
                PH_START:
                begin
                    phase_upd = PH_WHOLE;
                    if (item.character == CH_MINUS)
                    begin
                        err_upd = ST_NEG_EMPTY;
                    end
                end
                PH_FRAC:
                begin
                    if (!is_digit || (cnt_reg >= CNT_W'(FRAC_PLACES)))
                    begin
                        err_upd = ST_BAD_FRAC;
                    end
                    else
                    begin
                        total_upd = total_add[63:0];
                        tovf_upd  = tovf_reg | total_add[64];
                        cnt_upd   = cnt_reg + CNT_W'(1);
                    end
                end
                default:
                begin
                end
            endcase

            if (whole_path)
            begin
                if (item.character == CH_DOT)
                begin
                    if (!seen_reg)
                    begin
                        err_upd = ST_NO_WHOLE;
                    end
                    else
                    begin
                        phase_upd = PH_FRAC;
                    end
                end
                else if (!is_digit)
                begin
                    err_upd = ST_BAD_WHOLE;
                end
                else if (whole_ovf)
                begin
                    err_upd = ST_OVERFLOW;
                end
                else
                begin
                    whole_upd = whole_mul[63:0];
                    seen_upd  = 1'b1;
                    total_upd = total_mul[63:0];
                    tovf_upd  = tovf_reg | (|total_mul[67:64]);
                end
            end
        end

        phase_next = phase_reg;
        err_next   = err_reg;
        whole_next = whole_reg;
        seen_next  = seen_reg;
        total_next = total_reg;
        tovf_next  = tovf_reg;
        cnt_next   = cnt_reg;

        if (take)
        begin
            if (item.last_char)
            begin
                phase_next = PH_START;
                err_next   = ST_OK;
                whole_next = '0;
                seen_next  = 1'b0;
                total_next = '0;
                tovf_next  = 1'b0;
                cnt_next   = '0;
            end
            else
            begin
                phase_next = phase_upd;
                err_next   = err_upd;
                whole_next = whole_upd;
                seen_next  = seen_upd;
                total_next = total_upd;
                tovf_next  = tovf_upd;
                cnt_next   = cnt_upd;
            end
        end
    end

    // Result
    always_comb
    begin
        status_t st;
        st = err_upd;
        if (st == ST_OK)
        begin
            if (phase_upd == PH_START)
            begin
                st = ST_NEG_EMPTY;
            end
            else if ((phase_upd == PH_WHOLE) && !seen_upd)
            begin
                st = ST_NO_DIGITS;
            end
            else if (tovf_upd)
            begin
                st = ST_OVERFLOW;
            end
        end
        res_valid       = take && item.last_char;
        res.status      = st;
        res.price_micro = (st == ST_OK) ? total_upd : 64'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_START;
            err_reg   <= ST_OK;
            whole_reg <= '0;
            seen_reg  <= 1'b0;
            total_reg <= '0;
            tovf_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            err_reg   <= err_next;
            whole_reg <= whole_next;
            seen_reg  <= seen_next;
            total_reg <= total_next;
            tovf_reg  <= tovf_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/decimal_price_parser.sv =====
// Top level of the decimal price parser: request handshakes and result buffering.
//
//  Channel | Direction | Handshake            | Payload
//  in      | input     | in_valid / in_ready  | in_data  (in_item_t)
//  out     | output    | out_valid / out_ready| out_data (out_item_t)
//
// One request per cycle while in_ready is high.
// The result of the last character is registered into the output slot,
// or into the skid slot while the output slot holds an older result.
// Two result slots; in_ready drops only while both hold unclaimed results.
// Reset returns the parser to the start of a string with no error.
`default_nettype none

module decimal_price_parser import dpp_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire in_item_t   in_data,
    output logic            out_valid,
    input  wire logic       out_ready,
    output out_item_t       out_data
);

    `include "decimal_price_parser_macros.svh"

    logic       take;
    logic       res_valid;
    out_item_t  res;

    logic       out_valid_reg, out_valid_next;
    out_item_t  out_data_reg, out_data_next;
    logic       skid_valid_reg, skid_valid_next;
    out_item_t  skid_data_reg, skid_data_next;
    logic       out_free;
    logic       out_err;

    assign in_ready  = !skid_valid_reg;
    assign take      = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_err   = out_valid_reg && (out_data_reg.status != ST_OK);

    dpp_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .item      (in_data),
        .res_valid (res_valid),
        .res       (res)
    );

    // Keep order: the skid slot always drains into the output slot first
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;

        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = res_valid;
                skid_data_next  = res;
            end
            else
            begin
                out_valid_next = res_valid;
                out_data_next  = res;
            end
        end
        else if (res_valid)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    `DPP_ASSERT_IMPL(a_skid_behind_out, skid_valid_reg, out_valid_reg, "skid full, output empty")
    `DPP_ASSERT_IMPL(a_error_zero_price, out_err, out_data_reg.price_micro == '0, "priced error")
    `DPP_ASSERT_NEXT(a_last_gives_result, res_valid, out_valid_reg, "result lost")

endmodule

`default_nettype wire

// ===== test/decimal_price_parser_tb.sv =====
// Self-checking testbench for the decimal price parser with directed and random price strings.
`timescale 1ns / 100ps

module decimal_price_parser_tb import dpp_pkg::*;;

    localparam logic [63:0] U64_MAX = '1;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_data;

    decimal_price_parser dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // Pending character requests, with a flag that holds a request until all prices are back
    in_item_t  char_q[$];
    bit        hold_q[$];
    out_item_t price_q[$];

    // Parser state mirrored by the price predictor
    phase_t      str_phase;
    logic [63:0] whole_val;
    logic        whole_digits_seen;
    logic [63:0] frac_val;
    int          frac_digits;
    status_t     first_status;

    int  fail_count;
    bit  req_taken;
    int  send_gap;
    int  stall_left;
    int  quiet_left[2];

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        forever
        begin
            #6 clk = ~clk;
        end
    end

    initial
    begin
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    initial
    begin
        #5000000;
        $display("tb: failure");
        $finish;
    end

    // Mostly short gaps, a few long ones, and quiet stretches with none.
    function automatic int pick_gap(input int side);
        int r;
        if (quiet_left[side] > 0)
        begin
            quiet_left[side]--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            quiet_left[side] = $urandom_range(20, 60);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Advance the mirrored parser by one request; return 1 with the price when the string ends.
    function automatic bit predict_price(input in_item_t req, output out_item_t price);
        logic [7:0]  c;
        logic [63:0] d;
        logic [63:0] frac;
        status_t     st;
        bit          to_whole;
        price = '0;
        c = req.character;
        to_whole = 1'b0;
        if (req.empty_marker)
        begin
            if (str_phase == PH_START && first_status == ST_OK)
                first_status = ST_NEG_EMPTY;
        end
        else if (first_status == ST_OK)
        begin
            case (str_phase)
                PH_START:
                begin
                    str_phase = PH_WHOLE;
                    if (c == CH_MINUS)
                        first_status = ST_NEG_EMPTY;
                    else if (c != CH_PLUS)
                        to_whole = 1'b1;
                end
                PH_WHOLE:
                begin
                    to_whole = 1'b1;
                end
                default:
                begin
                    if (c < CH_ZERO || c > CH_NINE || frac_digits >= FRAC_PLACES)
                        first_status = ST_BAD_FRAC;
                    else
                    begin
                        frac_val = frac_val * 64'd10 + 64'(c - CH_ZERO);
                        frac_digits++;
                    end
                end
            endcase
            if (to_whole)
            begin
                if (c == CH_DOT)
                begin
                    if (!whole_digits_seen)
                        first_status = ST_NO_WHOLE;
                    else
                        str_phase = PH_FRAC;
                end
                else if (c < CH_ZERO || c > CH_NINE)
                    first_status = ST_BAD_WHOLE;
                else
                begin
                    d = 64'(c - CH_ZERO);
                    if (whole_val > (U64_MAX - d) / 64'd10)
                        first_status = ST_OVERFLOW;
                    else
                    begin
                        whole_val = whole_val * 64'd10 + d;
                        whole_digits_seen = 1'b1;
                    end
                end
            end
        end

        if (!req.last_char)
            return 1'b0;

        st = first_status;
        if (st == ST_OK && str_phase == PH_START)
            st = ST_NEG_EMPTY;
        if (st == ST_OK && str_phase == PH_WHOLE && !whole_digits_seen)
            st = ST_NO_DIGITS;
        if (st == ST_OK)
        begin
            frac = frac_val;
            for (int n = frac_digits; n < FRAC_PLACES; n++)
                frac = frac * 64'd10;
            if (whole_val > (U64_MAX - frac) / SCALE)
                st = ST_OVERFLOW;
            else
                price.price_micro = whole_val * SCALE + frac;
        end
        if (st != ST_OK)
            price.price_micro = '0;
        price.status = st;

        str_phase = PH_START;
        whole_val = '0;
        whole_digits_seen = 1'b0;
        frac_val = '0;
        frac_digits = 0;
        first_status = ST_OK;
        return 1'b1;
    endfunction

    function automatic void add_char(ref in_item_t q[$], input logic [7:0] c,
                                     input bit empty_item);
        in_item_t it;
        it.character = c;
        it.last_char = 1'b0;
        it.empty_marker = empty_item;
        q.push_back(it);
    endfunction

    function automatic void add_text(ref in_item_t q[$], input string s);
        for (int i = 0; i < s.len(); i++)
            add_char(q, s[i], 1'b0);
    endfunction

    function automatic void add_digits(ref in_item_t q[$], input int n);
        for (int i = 0; i < n; i++)
            add_char(q, CH_ZERO + 8'($urandom_range(0, 9)), 1'b0);
    endfunction

    // Mark the end of the string and move it to the send queue.
    function automatic void commit_string(ref in_item_t q[$], input bit hold);
        in_item_t it;
        it = q.pop_back();
        it.last_char = 1'b1;
        q.push_back(it);
        foreach (q[i])
        begin
            char_q.push_back(q[i]);
            hold_q.push_back(hold && i == 0);
        end
    endfunction

    function automatic void queue_random_string();
        in_item_t str[$];
        int       kind;
        int       r;
        int       pos;
        in_item_t blank;
        kind = $urandom_range(0, 99);
        if (kind < 70)
        begin
            if ($urandom_range(0, 4) == 0)
                add_char(str, CH_PLUS, 1'b0);
            r = $urandom_range(0, 9);
            if (r == 0)
            begin
                // probe the 64-bit limit on the whole part
                add_text(str, "1844674407370955161");
                add_digits(str, 1);
            end
            else if (r == 1)
            begin
                // probe the limit on the scaled total
                add_text(str, "18446744073709.5516");
                add_digits(str, 2);
            end
            else
            begin
                add_digits(str, ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20)
                                                           : $urandom_range(1, 6));
            end
            if (r != 1 && $urandom_range(0, 9) < 7)
            begin
                add_char(str, CH_DOT, 1'b0);
                add_digits(str, ($urandom_range(0, 11) == 0) ? 7 : $urandom_range(0, 6));
            end
            if ($urandom_range(0, 9) == 0)
            begin
                pos = $urandom_range(0, str.size() - 1);
                str[pos].character = 8'($urandom_range(0, 255));
            end
            if ($urandom_range(0, 14) == 0)
            begin
                blank.character = 8'($urandom_range(0, 255));
                blank.last_char = 1'b0;
                blank.empty_marker = 1'b1;
                str.insert($urandom_range(1, str.size()), blank);
            end
        end
        else if (kind < 80)
        begin
            repeat ($urandom_range(1, 5))
                add_char(str, 8'($urandom_range(0, 255)), 1'b0);
        end
        else if (kind < 88)
        begin
            add_char(str, ($urandom_range(0, 1) == 0) ? CH_MINUS : CH_DOT, 1'b0);
            add_digits(str, $urandom_range(1, 4));
        end
        else
        begin
            add_char(str, 8'($urandom_range(0, 255)), 1'b1);
            if (kind >= 94)
            begin
                repeat ($urandom_range(0, 3))
                    add_char(str, 8'($urandom_range(0, 255)), 1'b0);
            end
        end
        commit_string(str, $urandom_range(0, 24) == 0);
    endfunction

    initial
    begin
        in_item_t str[$];
        str_phase = PH_START;
        whole_val = '0;
        whole_digits_seen = 1'b0;
        frac_val = '0;
        frac_digits = 0;
        first_status = ST_OK;
        fail_count = 0;
        req_taken = 1'b0;
        send_gap = 0;
        stall_left = 0;
        quiet_left[0] = 0;
        quiet_left[1] = 0;

        add_text(str, "0");                      commit_string(str, 1'b0); str = {};
        add_text(str, "+7");                     commit_string(str, 1'b0); str = {};
        add_text(str, "+");                      commit_string(str, 1'b0); str = {};
        add_text(str, "-5");                     commit_string(str, 1'b0); str = {};
        add_text(str, ".5");                     commit_string(str, 1'b0); str = {};
        add_text(str, "+.5");                    commit_string(str, 1'b0); str = {};
        add_text(str, "5.");                     commit_string(str, 1'b0); str = {};
        add_text(str, "1.123456");               commit_string(str, 1'b0); str = {};
        add_text(str, "1.1234567");              commit_string(str, 1'b0); str = {};
        add_text(str, "1..2");                   commit_string(str, 1'b0); str = {};
        add_text(str, "1.2a");                   commit_string(str, 1'b0); str = {};
        add_text(str, "12x4");                   commit_string(str, 1'b0); str = {};
        add_text(str, "000123.45");              commit_string(str, 1'b1); str = {};
        add_text(str, "18446744073709.551615");  commit_string(str, 1'b0); str = {};
        add_text(str, "18446744073709.551616");  commit_string(str, 1'b0); str = {};
        add_text(str, "18446744073709551615");   commit_string(str, 1'b0); str = {};
        add_text(str, "18446744073709551616");   commit_string(str, 1'b0); str = {};
        add_char(str, 8'hff, 1'b1);              commit_string(str, 1'b0); str = {};
        // empty marker at the start, then a digit that ends the string
        add_char(str, 8'h00, 1'b1);
        add_text(str, "9");                      commit_string(str, 1'b0); str = {};
        // empty marker inside a string, and as its final request
        add_text(str, "3");
        add_char(str, 8'h55, 1'b1);
        add_text(str, ".5");
        add_char(str, 8'haa, 1'b1);              commit_string(str, 1'b0); str = {};
        add_char(str, 8'h00, 1'b0);              commit_string(str, 1'b0); str = {};
        add_text(str, "1.-");                    commit_string(str, 1'b1); str = {};

        while (char_q.size() < 550)
            queue_random_string();

        @(posedge rst_n);
        @(negedge clk);
        while (char_q.size() != 0 || in_valid)
            @(negedge clk);
        while (price_q.size() != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
        if (fail_count == 0 && price_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    always @(negedge clk)
    begin : drive_chars
        bit send;
        if (rst_n && !(in_valid && !req_taken))
        begin
            send = 1'b0;
            if (send_gap > 0)
                send_gap--;
            else if (char_q.size() != 0 && !(hold_q[0] && price_q.size() != 0))
                send = 1'b1;
            if (send)
            begin
                in_data <= char_q.pop_front();
                void'(hold_q.pop_front());
                send_gap = pick_gap(0);
            end
            in_valid <= send;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                out_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    stall_left = pick_gap(1);
            end
        end
    end

    always @(posedge clk)
    begin : check_prices
        out_item_t want;
        out_item_t predicted;
        if (rst_n)
        begin
            // retire the oldest price before queuing a new one
            if (out_valid && out_ready)
            begin
                if (price_q.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected price %0d status %0d",
                                 out_data.price_micro, out_data.status);
                    fail_count++;
                end
                else
                begin
                    want = price_q.pop_front();
                    if (out_data.price_micro !== want.price_micro ||
                        out_data.status !== want.status)
                    begin
                        if (fail_count < 10)
                            $display("price mismatch: expected %0d status %0d, got %0d status %0d",
                                     want.price_micro, want.status,
                                     out_data.price_micro, out_data.status);
                        fail_count++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                if (predict_price(in_data, predicted))
                    price_q.push_back(predicted);
            end
            req_taken <= in_valid && in_ready;
        end
    end

endmodule
